// ----- hw/rtl/latlon_to_mercator_pixel_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Mercator pixel pipeline
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LATLON_TO_MERCATOR_PIXEL_ASSERT_SVH
`define LATLON_TO_MERCATOR_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
`define LTMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ltmp assertion failed");
`define LTMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ltmp assertion failed");
`else
`define LTMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LTMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/ltmp_pkg.sv -----
// ----------------------------------------------------------------------------
// ltmp_pkg
// Types and fixed-point constants of the Mercator pixel pipeline.
// ----------------------------------------------------------------------------
package ltmp_pkg;

	localparam logic [63:0] Q62_ONE    = 64'h4000_0000_0000_0000;
	localparam logic [63:0] PI_Q60     = 64'h3243_F6A8_885A_308D;
	localparam logic [63:0] LN2_Q64    = 64'hB172_17F7_D1CF_79AB;
	localparam logic [63:0] INV2PI_Q64 = 64'h28BE_60DB_9391_054A;
	localparam logic [63:0] HALF_Q58   = 64'h0200_0000_0000_0000;
	localparam logic [27:0] LAT_LIMIT  = 28'd89182572;
	localparam logic signed [29:0] LON_HALF = 30'sd188743680;
	// 360 deg in Q20 is 45 * 2^23
	localparam int unsigned LON_SPAN_SHIFT = 23;
	localparam logic [63:0] LON_SPAN_ODD   = 64'd45;

	typedef struct packed {
		logic signed [28:0] longitude;
		logic signed [27:0] latitude;
		logic [4:0]         zoom;
	} item_t;

	typedef struct packed {
		logic [26:0] pixel_x;
		logic [25:0] pixel_y;
		logic        clipped;
	} result_t;

	// working context that travels down the pipeline
	typedef struct packed {
		logic [4:0]  zoom;
		logic        neg;
		logic        clipped;
		logic [3:0]  e;
		logic [26:0] px;
		logic [63:0] r0;
		logic [63:0] r1;
		logic [63:0] r2;
		logic [63:0] r3;
	} ctx_t;

	function automatic logic [63:0] q62(input logic [127:0] p);
		return p[125:62];
	endfunction

	function automatic logic [63:0] hi64(input logic [127:0] p);
		return p[127:64];
	endfunction

endpackage

// ----- hw/rtl/latlon_to_mercator_pixel.sv -----
// ----------------------------------------------------------------------------
// latlon_to_mercator_pixel
// Spherical Web Mercator projection of a point to global pixel coordinates.
// ----------------------------------------------------------------------------
// Input: a transaction is taken at a rising edge with start high and busy low.
// item carries longitude and latitude (degrees, Q20) and the zoom level.
// busy stays low: the pipeline takes one point every clock cycle.
// Output: done strobes for one cycle with result (pixel_x, pixel_y, clipped),
// in input order. The pipeline is a chain of 64x64 multipliers (two stages
// each, built from 32x32 partial products): 11 sine/cosine series steps of
// five stages and 62 log2 squaring steps of two stages make up most of it.
// Latitudes beyond the Mercator limit give row 0 (north) or W-1 (south)
// with clipped set; rows outside the map otherwise saturate to 0..W-1.
// Reset clears all valid bits; points in flight are dropped.
// The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
`include "latlon_to_mercator_pixel_assert.svh"

module latlon_to_mercator_pixel import ltmp_pkg::*; #(
	parameter int TILE_EDGE_PIXELS = 256,
	parameter int MAX_ZOOM         = 18
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam logic [63:0] TILE  = 64'(TILE_EDGE_PIXELS);
	localparam logic [4:0]  ZMAX  = 5'(MAX_ZOOM);
	localparam logic [63:0] M45   = 64'hFFFF_FFFF_FFFF_FFFF / LON_SPAN_ODD;
	localparam logic [63:0] PIDEG = PI_Q60 / 64'd180;
	localparam int          NT    = 11;
	localparam int          NL    = 62;

	// ---------------- front end ----------------
	logic signed [29:0] lon_c;
	logic [28:0]        lon_off;
	logic [4:0]         zs;
	logic [27:0]        lat_a;
	ctx_t               fc;
	logic               valid_s1;
	ctx_t               ctx_s1;

	always_comb begin
		lon_c = 30'(item.longitude);
		if (lon_c > LON_HALF) lon_c = LON_HALF;
		if (lon_c < -LON_HALF) lon_c = -LON_HALF;
		lon_off = 29'(lon_c + LON_HALF);
		zs      = (item.zoom > ZMAX) ? ZMAX : item.zoom;
		lat_a   = item.latitude[27] ? 28'(-item.latitude) : 28'(item.latitude);
		fc         = '0;
		fc.zoom    = zs;
		fc.neg     = item.latitude[27];
		fc.clipped = lat_a > LAT_LIMIT;
		fc.r0      = 64'(lat_a);
		fc.r1      = ((64'(lon_off) * TILE) << zs) >> LON_SPAN_SHIFT;
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= fc;
	end

	// column quotient estimate and phi in Q62
	logic         vf;
	ctx_t         cf;
	logic [127:0] pf0, pf1;
	logic [63:0]  pq, prem;
	ctx_t         cfn;
	logic         valid_s2;
	ctx_t         ctx_s2;

	ltmp_mul2 u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s1), .in_ctx(ctx_s1),
		.a0(ctx_s1.r1), .b0(M45), .a1(ctx_s1.r0), .b1(PIDEG),
		.out_valid(vf), .out_ctx(cf), .p0(pf0), .p1(pf1)
	);

	always_comb begin
		pq   = hi64(pf0);
		prem = cf.r1 - pq * LON_SPAN_ODD;
		cfn    = cf;
		cfn.px = (prem >= LON_SPAN_ODD) ? 27'(pq + 64'd1) : 27'(pq);
		cfn.r0 = pf1[81:18];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= vf;
	end

	always_ff @(posedge clk) begin
		ctx_s2 <= cfn;
	end

	// x squared, then the series
	logic         vx;
	ctx_t         cx;
	logic [127:0] px0, px1;
	ctx_t         tc0;
	logic         tv [NT+1];
	ctx_t         tc [NT+1];

	ltmp_mul2 u_sq (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s2), .in_ctx(ctx_s2),
		.a0(ctx_s2.r0), .b0(ctx_s2.r0), .a1(64'd0), .b1(64'd0),
		.out_valid(vx), .out_ctx(cx), .p0(px0), .p1(px1)
	);

	always_comb begin
		tc0    = cx;
		tc0.r1 = q62(px0) | (px1[63:0] & 64'd0);
		tc0.r2 = Q62_ONE;
		tc0.r3 = Q62_ONE;
	end

	assign tv[0] = vx;
	assign tc[0] = tc0;

	for (genvar j = 0; j < NT; j++) begin : g_taylor
		ltmp_taylor_step #(.K(NT - j)) u_step (
			.clk(clk), .arst_n(arst_n), .in_valid(tv[j]), .in_ctx(tc[j]),
			.out_valid(tv[j+1]), .out_ctx(tc[j+1])
		);
	end

	// sine = x * series, cosine normalized into [1,2)
	logic         vs;
	ctx_t         cs;
	logic [127:0] ps0, ps1;
	logic [63:0]  cnorm;
	logic [3:0]   ecnt;
	ctx_t         cl;
	logic         valid_s3;
	ctx_t         ctx_s3;

	ltmp_mul2 u_sin (
		.clk(clk), .arst_n(arst_n), .in_valid(tv[NT]), .in_ctx(tc[NT]),
		.a0(tc[NT].r0), .b0(tc[NT].r2), .a1(64'd0), .b1(64'd0),
		.out_valid(vs), .out_ctx(cs), .p0(ps0), .p1(ps1)
	);

	always_comb begin
		cnorm = cs.r3;
		ecnt  = 4'd0;
		for (int n = 0; n < 8; n++) begin
			if (cnorm < Q62_ONE) begin
				cnorm = cnorm << 1;
				ecnt  = ecnt + 4'd1;
			end
		end
		if (cnorm < Q62_ONE) cnorm = Q62_ONE;
		cl    = cs;
		cl.e  = ecnt;
		cl.r0 = Q62_ONE + q62(ps0) + (ps1[63:0] & 64'd0);
		cl.r1 = 64'd0;
		cl.r2 = cnorm;
		cl.r3 = 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else valid_s3 <= vs;
	end

	always_ff @(posedge clk) begin
		ctx_s3 <= cl;
	end

	logic lv [NL+1];
	ctx_t lcx [NL+1];

	assign lv[0]  = valid_s3;
	assign lcx[0] = ctx_s3;

	for (genvar i = 0; i < NL; i++) begin : g_log2
		ltmp_log2_step #(.I(i)) u_step (
			.clk(clk), .arst_n(arst_n), .in_valid(lv[i]), .in_ctx(lcx[i]),
			.out_valid(lv[i+1]), .out_ctx(lcx[i+1])
		);
	end

	// m = ln2 * log2 ratio, g = m / 2pi, row fraction times world edge
	logic [63:0]  lsum;
	logic         vm, vg, vp;
	ctx_t         cm, cg, cp;
	logic [127:0] pm0, pm1, pg0, pg1, pp0, pp1;
	logic [63:0]  gval, fval, wf, wz, py;
	result_t      res;
	logic         done_q;
	result_t      result_q;

	assign lsum = (lcx[NL].r1 >> 4) + (64'(lcx[NL].e) << 58) - (lcx[NL].r3 >> 4);

	ltmp_mul2 u_ln (
		.clk(clk), .arst_n(arst_n), .in_valid(lv[NL]), .in_ctx(lcx[NL]),
		.a0(lsum), .b0(LN2_Q64), .a1(64'd0), .b1(64'd0),
		.out_valid(vm), .out_ctx(cm), .p0(pm0), .p1(pm1)
	);

	ltmp_mul2 u_scale (
		.clk(clk), .arst_n(arst_n), .in_valid(vm), .in_ctx(cm),
		.a0(hi64(pm0) | (pm1[63:0] & 64'd0)), .b0(INV2PI_Q64),
		.a1(64'd0), .b1(64'd0),
		.out_valid(vg), .out_ctx(cg), .p0(pg0), .p1(pg1)
	);

	always_comb begin
		gval = hi64(pg0) | (pg1[63:0] & 64'd0);
		wz   = TILE << cg.zoom;
		if (!cg.neg) fval = (gval > HALF_Q58) ? 64'd0 : HALF_Q58 - gval;
		else fval = HALF_Q58 + gval;
	end

	ltmp_mul2 u_row (
		.clk(clk), .arst_n(arst_n), .in_valid(vg), .in_ctx(cg),
		.a0(fval), .b0(wz), .a1(64'd0), .b1(64'd0),
		.out_valid(vp), .out_ctx(cp), .p0(pp0), .p1(pp1)
	);

	always_comb begin
		wf = TILE << cp.zoom;
		py = pp0[121:58] | (pp1[63:0] & 64'd0);
		if (cp.clipped) py = cp.neg ? wf - 64'd1 : 64'd0;
		else if (py >= wf) py = wf - 64'd1;
		res.pixel_x = cp.px;
		res.pixel_y = py[25:0];
		res.clipped = cp.clipped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= vp;
	end

	always_ff @(posedge clk) begin
		result_q <= res;
	end

	assign done   = done_q;
	assign result = result_q;

	// reciprocal estimate of the column is at most one short
	`LTMP_ASSERT_IMP(a_col_rem, clk, arst_n, vf, prem < 64'd90)
	// log2 arguments lie in [1,2) for latitudes inside the limit
	`LTMP_ASSERT_IMP(a_log_arg, clk, arst_n, valid_s3 && !ctx_s3.clipped,
		ctx_s3.r0[63:62] == 2'b01 && ctx_s3.r2[63:62] == 2'b01)
	// clipped rows sit on a map edge
	`LTMP_ASSERT_IMP(a_clip_edge, clk, arst_n, vp && cp.clipped,
		py == 64'd0 || py == wf - 64'd1)
	// a point beyond the limit is flagged on entry
	`LTMP_ASSERT_NXT(a_clip_flag, clk, arst_n, start && !busy && lat_a > LAT_LIMIT,
		valid_s1 && ctx_s1.clipped)

endmodule

// ----- hw/rtl/ltmp_mul2.sv -----
// ----------------------------------------------------------------------------
// ltmp_mul2
// Two 64x64 full products in parallel, 32-bit partial products, two stages.
// ----------------------------------------------------------------------------
module ltmp_mul2 import ltmp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  ctx_t         in_ctx,
	input  logic [63:0]  a0,
	input  logic [63:0]  b0,
	input  logic [63:0]  a1,
	input  logic [63:0]  b1,
	output logic         out_valid,
	output ctx_t         out_ctx,
	output logic [127:0] p0,
	output logic [127:0] p1
);

	logic [63:0]  opa [2];
	logic [63:0]  opb [2];
	logic [63:0]  pp_s1 [2][4];
	logic         valid_s1, valid_s2;
	ctx_t         ctx_s1, ctx_s2;
	logic [127:0] prod_s2 [2];

	assign opa[0] = a0;
	assign opb[0] = b0;
	assign opa[1] = a1;
	assign opb[1] = b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= in_ctx;
		ctx_s2 <= ctx_s1;
		for (int l = 0; l < 2; l++) begin
			pp_s1[l][0] <= opa[l][31:0]  * opb[l][31:0];
			pp_s1[l][1] <= opa[l][31:0]  * opb[l][63:32];
			pp_s1[l][2] <= opa[l][63:32] * opb[l][31:0];
			pp_s1[l][3] <= opa[l][63:32] * opb[l][63:32];
			prod_s2[l] <= 128'(pp_s1[l][0]) + (128'(pp_s1[l][1]) << 32)
				+ (128'(pp_s1[l][2]) << 32) + (128'(pp_s1[l][3]) << 64);
		end
	end

	assign out_valid = valid_s2;
	assign out_ctx   = ctx_s2;
	assign p0        = prod_s2[0];
	assign p1        = prod_s2[1];

endmodule

// ----- hw/rtl/ltmp_taylor_step.sv -----
// ----------------------------------------------------------------------------
// ltmp_taylor_step
// One Horner step of the sine and cosine series: acc = 1 - x2*acc / d.
// Division by the constant d uses a reciprocal product plus one correction.
// ----------------------------------------------------------------------------
module ltmp_taylor_step import ltmp_pkg::*; #(
	parameter int K = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  ctx_t in_ctx,
	output logic out_valid,
	output ctx_t out_ctx
);

	// r1 = x2, r2 = sine accumulator, r3 = cosine accumulator
	localparam logic [63:0] DS = 64'(2 * K * (2 * K + 1));
	localparam logic [63:0] DC = 64'((2 * K - 1) * 2 * K);
	localparam logic [63:0] MS = 64'hFFFF_FFFF_FFFF_FFFF / DS;
	localparam logic [63:0] MC = 64'hFFFF_FFFF_FFFF_FFFF / DC;

	logic         va, vb;
	ctx_t         ca, ct, cb, cn;
	logic [127:0] pa0, pa1, pb0, pb1;
	logic [63:0]  qs, qc, rs, rc;
	logic         valid_s5;
	ctx_t         ctx_s5;

	ltmp_mul2 u_prod (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ctx(in_ctx),
		.a0(in_ctx.r1), .b0(in_ctx.r2), .a1(in_ctx.r1), .b1(in_ctx.r3),
		.out_valid(va), .out_ctx(ca), .p0(pa0), .p1(pa1)
	);

	always_comb begin
		ct    = ca;
		ct.r2 = q62(pa0);
		ct.r3 = q62(pa1);
	end

	ltmp_mul2 u_recip (
		.clk(clk), .arst_n(arst_n), .in_valid(va), .in_ctx(ct),
		.a0(ct.r2), .b0(MS), .a1(ct.r3), .b1(MC),
		.out_valid(vb), .out_ctx(cb), .p0(pb0), .p1(pb1)
	);

	// estimate is exact or one short
	always_comb begin
		qs = hi64(pb0);
		qc = hi64(pb1);
		rs = cb.r2 - qs * DS;
		rc = cb.r3 - qc * DC;
		if (rs >= DS) qs = qs + 64'd1;
		if (rc >= DC) qc = qc + 64'd1;
		cn    = cb;
		cn.r2 = Q62_ONE - qs;
		cn.r3 = Q62_ONE - qc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s5 <= 1'b0;
		else valid_s5 <= vb;
	end

	always_ff @(posedge clk) begin
		ctx_s5 <= cn;
	end

	assign out_valid = valid_s5;
	assign out_ctx   = ctx_s5;

endmodule

// ----- hw/rtl/ltmp_log2_step.sv -----
// ----------------------------------------------------------------------------
// ltmp_log2_step
// One squaring step of the log2 fraction, two lanes (1+sin and cos).
// ----------------------------------------------------------------------------
module ltmp_log2_step import ltmp_pkg::*; #(
	parameter int I = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  ctx_t in_ctx,
	output logic out_valid,
	output ctx_t out_ctx
);

	// r0/r1 = value/result of lane a, r2/r3 = value/result of lane c
	localparam logic [63:0] BIT = 64'd1 << (61 - I);

	ctx_t         cm;
	logic [127:0] p0, p1;
	logic [63:0]  sa, sc;

	ltmp_mul2 u_sq (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ctx(in_ctx),
		.a0(in_ctx.r0), .b0(in_ctx.r0), .a1(in_ctx.r2), .b1(in_ctx.r2),
		.out_valid(out_valid), .out_ctx(cm), .p0(p0), .p1(p1)
	);

	always_comb begin
		sa      = q62(p0);
		sc      = q62(p1);
		out_ctx = cm;
		out_ctx.r0 = sa[63] ? (sa >> 1) : sa;
		out_ctx.r1 = sa[63] ? (cm.r1 | BIT) : cm.r1;
		out_ctx.r2 = sc[63] ? (sc >> 1) : sc;
		out_ctx.r3 = sc[63] ? (cm.r3 | BIT) : cm.r3;
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mercator pixel pipeline testbench
// Drives points through the projection and checks each row, column and clip
// flag against a fixed-point predictor, in order, with random sender bursts.
// ----------------------------------------------------------------------------

class pixel_scoreboard;
	ltmp_pkg::result_t pending[$];
	int errors;

	static function logic [127:0] wide_mul(logic [63:0] a, logic [63:0] b);
		return {64'd0, a} * {64'd0, b};
	endfunction

	static function logic [63:0] mq62(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = wide_mul(a, b);
		return p[125:62];
	endfunction

	static function logic [63:0] mhi(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = wide_mul(a, b);
		return p[127:64];
	endfunction

	// fractional part of log2 for a value in [1,2) Q62
	static function logic [63:0] log2_fraction(logic [63:0] v);
		logic [63:0] r;
		r = 64'd0;
		for (int i = 0; i < 62; i++) begin
			v = mq62(v, v);
			if (v >= 64'h8000_0000_0000_0000) begin
				v = v >> 1;
				r[61 - i] = 1'b1;
			end
		end
		return r;
	endfunction

	static function ltmp_pkg::result_t project(ltmp_pkg::item_t it);
		ltmp_pkg::result_t res;
		logic [63:0] w, a, x, x2, sacc, cacc, s, c, la, lc, l, m, g, f, k2, py;
		logic [127:0] p;
		longint lon;
		int unsigned zm, e;
		zm = it.zoom;
		if (zm > 18) zm = 18;
		w = 64'd256 << zm;
		lon = it.longitude;
		if (lon > 188743680) lon = 188743680;
		if (lon < -188743680) lon = -188743680;
		res.pixel_x = 27'((64'(lon + 188743680) * w) / 64'd377487360);
		res.clipped = 1'b0;
		a = (it.latitude < 0) ? 64'(-longint'(it.latitude)) : 64'(it.latitude);
		if (a > 64'd89182572) begin
			res.clipped = 1'b1;
			py = (it.latitude > 0) ? 64'd0 : w - 64'd1;
		end else begin
			p = wide_mul(a, ltmp_pkg::PI_Q60 / 64'd180);
			x = p[81:18];
			x2 = mq62(x, x);
			sacc = ltmp_pkg::Q62_ONE;
			cacc = ltmp_pkg::Q62_ONE;
			for (int k = 11; k >= 1; k--) begin
				k2 = 64'(2 * k);
				sacc = ltmp_pkg::Q62_ONE - mq62(x2, sacc) / (k2 * (k2 + 64'd1));
				cacc = ltmp_pkg::Q62_ONE - mq62(x2, cacc) / ((k2 - 64'd1) * k2);
			end
			s = mq62(x, sacc);
			c = cacc;
			la = log2_fraction(ltmp_pkg::Q62_ONE + s);
			e = 0;
			while (c < ltmp_pkg::Q62_ONE && e < 8) begin
				c = c << 1;
				e++;
			end
			if (c < ltmp_pkg::Q62_ONE) c = ltmp_pkg::Q62_ONE;
			lc = log2_fraction(c);
			l = (la >> 4) + (64'(e) << 58) - (lc >> 4);
			m = mhi(l, ltmp_pkg::LN2_Q64);
			g = mhi(m, ltmp_pkg::INV2PI_Q64);
			if (it.latitude >= 0)
				f = (g > 64'h0200_0000_0000_0000) ? 64'd0 : 64'h0200_0000_0000_0000 - g;
			else
				f = 64'h0200_0000_0000_0000 + g;
			p = wide_mul(f, w);
			py = p[121:58];
			if (py >= w) py = w - 64'd1;
		end
		res.pixel_y = py[25:0];
		return res;
	endfunction

	function void note_point(ltmp_pkg::item_t it);
		pending.push_back(project(it));
	endfunction

	function void check_pixel(ltmp_pkg::result_t got);
		ltmp_pkg::result_t exp_r;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got.pixel_x !== exp_r.pixel_x)
			$display("%0t: pixel_x exp %0d got %0d", $time, exp_r.pixel_x, got.pixel_x);
		if (got.pixel_y !== exp_r.pixel_y)
			$display("%0t: pixel_y exp %0d got %0d", $time, exp_r.pixel_y, got.pixel_y);
		if (got.clipped !== exp_r.clipped)
			$display("%0t: clipped exp %0b got %0b", $time, exp_r.clipped, got.clipped);
		if (got !== exp_r) errors++;
	endfunction
endclass

module tb;
	import ltmp_pkg::*;

	localparam int WATCHDOG = 20000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;

	pixel_scoreboard sb;
	int idle_cycles = 0;

	latlon_to_mercator_pixel DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result sampling and point bookkeeping at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_point(item);
			if (done)
				sb.check_pixel(result);
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// present one point, hold it until taken
	task automatic send_point(logic signed [28:0] lon, logic signed [27:0] lat,
			logic [4:0] zm);
		start <= 1;
		item <= '{longitude: lon, latitude: lat, zoom: zm};
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic pause(int n);
		start <= 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_random();
		logic signed [28:0] lon;
		logic signed [27:0] lat;
		logic [4:0] zm;
		int sel;
		sel = $urandom_range(0, 9);
		lon = 29'($urandom);
		if (sel < 7) lon = 29'($signed($urandom_range(0, 377487360)) - 188743680);
		lat = 28'($urandom);
		if (sel < 6) lat = 28'($signed($urandom_range(0, 178365144)) - 89182572);
		else if (sel == 6) lat = 28'($signed($urandom_range(0, 200)) + 89182472);
		else if (sel == 7) lat = 28'(-$signed($urandom_range(0, 200)) - 89182472);
		zm = 5'($urandom_range(0, 18));
		if (sel == 9) zm = 5'($urandom);
		send_point(lon, lat, zm);
	endtask

	initial begin
		sb = new();
		start = 0;
		item = '0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// corners, poles, clip boundary, zoom extremes and saturation
		send_point(29'sd0, 28'sd0, 5'd0);
		send_point(-29'sd188743680, 28'sd0, 5'd18);
		send_point(29'sd188743680, 28'sd0, 5'd18);
		send_point(29'h0FFF_FFFF, 28'sd0, 5'd18);
		send_point(29'h1000_0000, 28'sd0, 5'd18);
		send_point(29'sd0, 28'sd89182572, 5'd18);
		send_point(29'sd0, 28'sd89182573, 5'd18);
		send_point(29'sd0, -28'sd89182572, 5'd18);
		send_point(29'sd0, -28'sd89182573, 5'd18);
		send_point(29'sd0, 28'sd94371840, 5'd1);
		send_point(29'sd0, -28'sd94371840, 5'd1);
		send_point(29'sd0, 28'h7FF_FFFF, 5'd31);
		send_point(29'sd0, 28'h800_0000, 5'd19);
		send_point(29'sd1, 28'sd1, 5'd18);
		send_point(-29'sd1, -28'sd1, 5'd18);
		send_point(29'sd12345678, 28'sd40000000, 5'd10);
		send_point(-29'sd100000000, -28'sd60000000, 5'd5);

		// wait for the pipeline to drain
		pause(1);
		while (sb.pending.size() != 0) @(negedge clk);

		for (int n = 0; n < 1350; ) begin
			int burst;
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst; b++, n++) send_random();
			if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
		end
		start <= 0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (250) @(negedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
